// ===== src/wrsi_pkg.sv =====
// ----------------------------------------------------------------------------
// Wilder RSI package
// Shared constants and the sequencer state type of the RSI indicator unit.
// ----------------------------------------------------------------------------
package wrsi_pkg;

    localparam int PRICE_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int MAX_PERIOD_DEF = 255;

    // Fixed widths of the period register and of the RSI result field.
    localparam int PERIOD_W = 8;
    localparam int RSI_W    = 23;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_GAIN,
        ST_WAIT_GAIN,
        ST_LOAD_LOSS,
        ST_WAIT_LOSS,
        ST_LOAD_RSI,
        ST_WAIT_RSI
    } seq_state_t;

endpackage

// ===== src/wilder_rsi_indicator_unit.sv =====
// ----------------------------------------------------------------------------
// Wilder RSI indicator unit
// Relative strength index over a stream of closing prices with Wilder
// smoothing, in fixed point, using one shared serial divider.
// ----------------------------------------------------------------------------
// Usage:
// Each input beat on in_valid/in_ready carries one closing price; each one
// produces exactly one output beat on out_valid/out_ready with ready_res and
// rsi_value. The period register is written through cfg_write_en and
// cfg_write_data; the user must write it only while the unit is idle, and
// the unit itself does not enforce this. A write clears all history. A
// disabled period, the first price and the seeding changes before the last
// one give a not-ready beat in the cycle after acceptance. A change that
// ends seeding or is smoothed runs three divisions on the shared
// one-bit-per-cycle divider: two averages of PRICE_BITS+FRAC_BITS+9 steps
// and one RSI division of PRICE_BITS+2*FRAC_BITS+7 steps, or only the two
// averages when an average is zero. in_ready is low while the divider
// sequence runs. The result waits in an output register while the receiver
// stalls; a new price is taken only once that register is empty or being
// emptied. Reset sets the period to 14 and clears the price history and
// averages.
// ----------------------------------------------------------------------------
module wilder_rsi_indicator_unit #(
    parameter int PRICE_BITS = wrsi_pkg::PRICE_BITS_DEF,
    parameter int FRAC_BITS  = wrsi_pkg::FRAC_BITS_DEF,
    parameter int MAX_PERIOD = wrsi_pkg::MAX_PERIOD_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [wrsi_pkg::PERIOD_W-1:0]  cfg_write_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [PRICE_BITS-1:0]          price_tick,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           ready_res,
    output logic [wrsi_pkg::RSI_W-1:0]     rsi_value
);

    localparam int PW      = wrsi_pkg::PERIOD_W;
    localparam int RW      = wrsi_pkg::RSI_W;
    localparam int SUM_W   = PRICE_BITS + PW;
    localparam int AVG_W   = PRICE_BITS + FRAC_BITS;
    localparam int NA_W    = AVG_W + PW + 1;
    localparam int HUND_W  = FRAC_BITS + 7;
    localparam int NR_W    = AVG_W + HUND_W;
    localparam int N_W     = (NA_W > NR_W) ? NA_W : NR_W;
    localparam int D_W     = AVG_W + 1;
    localparam int CNT_W   = $clog2(N_W + 1);
    localparam int PER_TOP = (1 << PW) - 1;
    localparam logic [PW-1:0] PER_CAP =
        PW'((MAX_PERIOD > PER_TOP) ? PER_TOP : MAX_PERIOD);
    localparam logic [HUND_W-1:0] RSI_HUNDRED = HUND_W'(100) << FRAC_BITS;
    localparam logic [HUND_W-1:0] RSI_FIFTY   = HUND_W'(50) << FRAC_BITS;

    wrsi_pkg::seq_state_t state_reg, state_next;

    logic [PW-1:0]         period_reg, period_next;
    logic [PRICE_BITS-1:0] prev_price_reg, prev_price_next;
    logic                  have_prev_reg, have_prev_next;
    logic [PW-1:0]         seed_count_reg, seed_count_next;
    logic [SUM_W-1:0]      sum_gain_reg, sum_gain_next;
    logic [SUM_W-1:0]      sum_loss_reg, sum_loss_next;
    logic [AVG_W-1:0]      mean_gain_reg, mean_gain_next;
    logic [AVG_W-1:0]      mean_loss_reg, mean_loss_next;
    logic [PRICE_BITS-1:0] gain_reg, gain_next;
    logic [PRICE_BITS-1:0] loss_reg, loss_next;
    logic                  smooth_reg, smooth_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_ready_res_reg, out_ready_res_next;
    logic [RW-1:0]         out_rsi_reg, out_rsi_next;

    logic                  in_accept;
    logic                  rising;
    logic [PRICE_BITS-1:0] gain_c, loss_c;
    logic                  seeding, seed_last, quick;
    logic [PW-1:0]         period_less_one;
    logic                  pick_loss;
    logic [AVG_W-1:0]      avg_sel;
    logic [PRICE_BITS-1:0] move_sel;
    logic [SUM_W-1:0]      sum_sel;
    logic [AVG_W+PW-1:0]   avg_prod;
    logic [NA_W-1:0]       num_avg;
    logic [NR_W-1:0]       num_rsi;
    logic                  rsi_special;
    logic [RW-1:0]         rsi_special_val;

    logic                  div_start, div_done;
    logic [N_W-1:0]        div_numer, div_quot;
    logic [D_W-1:0]        div_divisor;
    logic [CNT_W-1:0]      div_steps;

    logic                  res_load, res_ready;
    logic [RW-1:0]         res_rsi;

    assign in_ready  = (state_reg == wrsi_pkg::ST_IDLE) && (!out_valid_reg || out_ready);
    assign in_accept = in_valid && in_ready;

    assign rising          = (price_tick > prev_price_reg);
    assign gain_c          = rising ? (price_tick - prev_price_reg) : '0;
    assign loss_c          = rising ? '0 : (prev_price_reg - price_tick);
    assign period_less_one = period_reg - PW'(1);
    assign seeding         = (seed_count_reg < period_reg);
    assign seed_last       = (seed_count_reg == period_less_one);
    assign quick           = (period_reg == '0) || !have_prev_reg || (seeding && !seed_last);

    // Shared average arithmetic: the seed divides the sum, smoothing divides
    // avg*(n-1) plus the new move, both scaled by the fraction bits.
    assign pick_loss = (state_reg == wrsi_pkg::ST_LOAD_LOSS);
    assign avg_sel   = pick_loss ? mean_loss_reg : mean_gain_reg;
    assign move_sel  = pick_loss ? loss_reg : gain_reg;
    assign sum_sel   = pick_loss ? sum_loss_reg : sum_gain_reg;
    assign avg_prod  = avg_sel * period_less_one;
    assign num_avg   = smooth_reg
                     ? (NA_W'(avg_prod) + (NA_W'(move_sel) << FRAC_BITS))
                     : (NA_W'(sum_sel) << FRAC_BITS);
    assign num_rsi   = NR_W'(mean_gain_reg) * NR_W'(RSI_HUNDRED);

    assign rsi_special = (mean_gain_reg == '0) || (mean_loss_reg == '0);

    always_comb
    begin
        if ((mean_gain_reg == '0) && (mean_loss_reg == '0))
            rsi_special_val = RW'(RSI_FIFTY);
        else if (mean_loss_reg == '0)
            rsi_special_val = RW'(RSI_HUNDRED);
        else
            rsi_special_val = '0;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wrsi_pkg::ST_IDLE:
                if (in_accept && !quick)
                    state_next = wrsi_pkg::ST_LOAD_GAIN;
            wrsi_pkg::ST_LOAD_GAIN:
                state_next = wrsi_pkg::ST_WAIT_GAIN;
            wrsi_pkg::ST_WAIT_GAIN:
                if (div_done)
                    state_next = wrsi_pkg::ST_LOAD_LOSS;
            wrsi_pkg::ST_LOAD_LOSS:
                state_next = wrsi_pkg::ST_WAIT_LOSS;
            wrsi_pkg::ST_WAIT_LOSS:
                if (div_done)
                    state_next = wrsi_pkg::ST_LOAD_RSI;
            wrsi_pkg::ST_LOAD_RSI:
                state_next = rsi_special ? wrsi_pkg::ST_IDLE : wrsi_pkg::ST_WAIT_RSI;
            wrsi_pkg::ST_WAIT_RSI:
                if (div_done)
                    state_next = wrsi_pkg::ST_IDLE;
            default:
                state_next = wrsi_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: divider commands and result loading.
    always_comb
    begin
        div_start   = 1'b0;
        div_numer   = N_W'(num_avg) << (N_W - NA_W);
        div_divisor = D_W'(period_reg);
        div_steps   = CNT_W'(NA_W);
        res_load    = 1'b0;
        res_ready   = 1'b0;
        res_rsi     = '0;
        unique case (state_reg)
            wrsi_pkg::ST_IDLE:
                res_load = in_accept && quick;
            wrsi_pkg::ST_LOAD_GAIN,
            wrsi_pkg::ST_LOAD_LOSS:
                div_start = 1'b1;
            wrsi_pkg::ST_LOAD_RSI:
            begin
                if (rsi_special)
                begin
                    res_load  = 1'b1;
                    res_ready = 1'b1;
                    res_rsi   = rsi_special_val;
                end
                else
                begin
                    div_start   = 1'b1;
                    div_numer   = N_W'(num_rsi) << (N_W - NR_W);
                    div_divisor = D_W'(mean_gain_reg) + D_W'(mean_loss_reg);
                    div_steps   = CNT_W'(NR_W);
                end
            end
            wrsi_pkg::ST_WAIT_RSI:
            begin
                res_load  = div_done;
                res_ready = 1'b1;
                res_rsi   = RW'(div_quot[HUND_W-1:0]);
            end
            wrsi_pkg::ST_WAIT_GAIN,
            wrsi_pkg::ST_WAIT_LOSS:
                res_load = 1'b0;
            default:
                res_load = 1'b0;
        endcase
    end

    // History, sums and averages.
    always_comb
    begin
        period_next     = period_reg;
        prev_price_next = prev_price_reg;
        have_prev_next  = have_prev_reg;
        seed_count_next = seed_count_reg;
        sum_gain_next   = sum_gain_reg;
        sum_loss_next   = sum_loss_reg;
        mean_gain_next  = mean_gain_reg;
        mean_loss_next  = mean_loss_reg;
        gain_next       = gain_reg;
        loss_next       = loss_reg;
        smooth_next     = smooth_reg;
        if (cfg_write_en)
        begin
            period_next     = (cfg_write_data > PER_CAP) ? PER_CAP : cfg_write_data;
            prev_price_next = '0;
            have_prev_next  = 1'b0;
            seed_count_next = '0;
            sum_gain_next   = '0;
            sum_loss_next   = '0;
            mean_gain_next  = '0;
            mean_loss_next  = '0;
        end
        else
        begin
            if ((state_reg == wrsi_pkg::ST_IDLE) && in_accept && (period_reg != '0))
            begin
                prev_price_next = price_tick;
                have_prev_next  = 1'b1;
                if (have_prev_reg)
                begin
                    gain_next   = gain_c;
                    loss_next   = loss_c;
                    smooth_next = !seeding;
                    if (seeding)
                    begin
                        sum_gain_next   = sum_gain_reg + SUM_W'(gain_c);
                        sum_loss_next   = sum_loss_reg + SUM_W'(loss_c);
                        seed_count_next = seed_count_reg + PW'(1);
                    end
                end
            end
            if ((state_reg == wrsi_pkg::ST_WAIT_GAIN) && div_done)
                mean_gain_next = div_quot[AVG_W-1:0];
            if ((state_reg == wrsi_pkg::ST_WAIT_LOSS) && div_done)
                mean_loss_next = div_quot[AVG_W-1:0];
        end
    end

    // Output register.
    always_comb
    begin
        out_valid_next     = out_valid_reg;
        out_ready_res_next = out_ready_res_reg;
        out_rsi_next       = out_rsi_reg;
        if (res_load)
        begin
            out_valid_next     = 1'b1;
            out_ready_res_next = res_ready;
            out_rsi_next       = res_rsi;
        end
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wrsi_pkg::ST_IDLE;
            period_reg     <= wrsi_pkg::PERIOD_RESET;
            prev_price_reg <= '0;
            have_prev_reg  <= 1'b0;
            seed_count_reg <= '0;
            sum_gain_reg   <= '0;
            sum_loss_reg   <= '0;
            mean_gain_reg  <= '0;
            mean_loss_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            period_reg     <= period_next;
            prev_price_reg <= prev_price_next;
            have_prev_reg  <= have_prev_next;
            seed_count_reg <= seed_count_next;
            sum_gain_reg   <= sum_gain_next;
            sum_loss_reg   <= sum_loss_next;
            mean_gain_reg  <= mean_gain_next;
            mean_loss_reg  <= mean_loss_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gain_reg          <= gain_next;
        loss_reg          <= loss_next;
        smooth_reg        <= smooth_next;
        out_ready_res_reg <= out_ready_res_next;
        out_rsi_reg       <= out_rsi_next;
    end

    wrsi_div #(
        .N_W (N_W),
        .D_W (D_W)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .numer   (div_numer),
        .divisor (div_divisor),
        .steps   (div_steps),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign out_valid = out_valid_reg;
    assign ready_res = out_ready_res_reg;
    assign rsi_value = out_rsi_reg;

`ifndef SYNTH
    // A finished division only ever arrives while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == wrsi_pkg::ST_WAIT_GAIN) ||
                      (state_reg == wrsi_pkg::ST_WAIT_LOSS) ||
                      (state_reg == wrsi_pkg::ST_WAIT_RSI)))
        else $error("divider finished outside a wait state");

    // A not-ready beat always carries a zero RSI.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ready_res) |-> (rsi_value == '0))
        else $error("not-ready beat with non-zero RSI");

    // The seed counter never runs past the period.
    assert property (@(posedge clk) disable iff (!rst_n)
        seed_count_reg <= period_reg)
        else $error("seed count exceeds period");
`endif

endmodule

// ===== src/wrsi_div.sv =====
// ----------------------------------------------------------------------------
// Wilder RSI serial divider
// Restoring unsigned divider, one quotient bit per cycle. The caller places
// the significant numerator bits at the top and gives the number of steps.
// ----------------------------------------------------------------------------
module wrsi_div #(
    parameter int N_W = 71,
    parameter int D_W = 49
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [N_W-1:0]               numer,
    input  logic [D_W-1:0]               divisor,
    input  logic [$clog2(N_W+1)-1:0]     steps,
    output logic                         done,
    output logic [N_W-1:0]               quot
);

    localparam int CNT_W = $clog2(N_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [N_W-1:0]   num_reg, num_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [D_W-1:0]   div_reg, div_next;

    logic [D_W:0]     rem_shift;
    logic [D_W:0]     rem_diff;
    logic             take;

    // The partial remainder stays below the divisor, so the shifted value is
    // below twice the divisor and one subtraction settles each bit.
    assign rem_shift = {rem_reg, num_reg[N_W-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign take      = (rem_shift >= {1'b0, div_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = steps;
            num_next  = numer;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            // Quotient bits shift in at the bottom as numerator bits leave the top.
            num_next = {num_reg[N_W-2:0], take};
            rem_next = take ? rem_diff[D_W-1:0] : rem_shift[D_W-1:0];
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign quot = num_reg;

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Wilder RSI indicator unit testbench
// Feeds closing prices to the unit over a range of period settings, predicts
// each result beat with an independent fixed-point RSI calculation, and checks
// every beat on the output channel against it. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FRAC     = wrsi_pkg::FRAC_BITS_DEF;
    localparam int RSI_W    = wrsi_pkg::RSI_W;
    localparam int PERIOD_W = wrsi_pkg::PERIOD_W;
    localparam logic [RSI_W-1:0] RSI_HUNDRED = RSI_W'(100 << FRAC);
    localparam logic [RSI_W-1:0] RSI_HALF    = RSI_W'(50 << FRAC);
    localparam int RANDOM_PRICES = 700;

    typedef struct packed {
        logic             ready;
        logic [RSI_W-1:0] value;
    } rsi_beat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write_en = 1'b0;
    logic [PERIOD_W-1:0] cfg_write_data = '0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [31:0]         price_tick = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                ready_res;
    logic [RSI_W-1:0]    rsi_value;

    // Prices waiting to be sent and the result beats they are expected to give.
    logic [31:0] price_backlog[$];
    rsi_beat_t   rsi_expected[$];

    int send_gap;
    int sink_stall;
    int send_gap_pct;
    int sink_stall_pct;
    bit calm_tail;
    int mismatch_count;

    // Predictor copy of the unit's period and price history.
    logic [PERIOD_W-1:0] period_q;
    logic [31:0]         last_price;
    bit                  have_last;
    logic [PERIOD_W-1:0] changes_summed;
    logic [39:0]         gain_sum;
    logic [39:0]         loss_sum;
    logic [63:0]         mean_gain;
    logic [63:0]         mean_loss;

    wilder_rsi_indicator_unit uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .price_tick     (price_tick),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .ready_res      (ready_res),
        .rsi_value      (rsi_value)
    );

    always #10 clk = ~clk;

    function automatic void clear_history();
        last_price     = '0;
        have_last      = 1'b0;
        changes_summed = '0;
        gain_sum       = '0;
        loss_sum       = '0;
        mean_gain      = '0;
        mean_loss      = '0;
    endfunction

    function automatic rsi_beat_t predict_rsi_beat(input logic [31:0] price);
        logic [63:0]  up;
        logic [63:0]  down;
        logic [63:0]  n;
        logic [127:0] scaled;
        rsi_beat_t    beat;
        beat = '0;
        up   = '0;
        down = '0;
        n    = 64'(period_q);
        if (period_q == 0)
            return beat;
        if (!have_last)
        begin
            last_price = price;
            have_last  = 1'b1;
            return beat;
        end
        if (price > last_price)
            up = 64'(price - last_price);
        else
            down = 64'(last_price - price);
        last_price = price;
        if (changes_summed < period_q)
        begin
            gain_sum       = gain_sum + 40'(up);
            loss_sum       = loss_sum + 40'(down);
            changes_summed = changes_summed + 1'b1;
            if (changes_summed < period_q)
                return beat;
            mean_gain = (64'(gain_sum) << FRAC) / n;
            mean_loss = (64'(loss_sum) << FRAC) / n;
        end
        else
        begin
            mean_gain = (mean_gain * (n - 64'd1) + (up << FRAC)) / n;
            mean_loss = (mean_loss * (n - 64'd1) + (down << FRAC)) / n;
        end
        beat.ready = 1'b1;
        if (mean_gain == 0 && mean_loss == 0)
            beat.value = RSI_HALF;
        else if (mean_loss == 0)
            beat.value = RSI_HUNDRED;
        else if (mean_gain == 0)
            beat.value = '0;
        else
        begin
            scaled     = 128'(mean_gain) * 128'(RSI_HUNDRED);
            beat.value = RSI_W'(scaled / 128'(mean_gain + mean_loss));
        end
        return beat;
    endfunction

    function automatic logic [31:0] next_price(input logic [31:0] prev);
        logic [31:0] step;
        step = $urandom & ((32'd1 << $urandom_range(0, 31)) - 32'd1);
        case ($urandom_range(0, 11))
            0: return $urandom;
            1: return '0;
            2: return '1;
            3, 4: return prev;
            default:
            begin
                if ($urandom_range(0, 1))
                    return (step > ~prev) ? '1 : prev + step;
                else
                    return (prev < step) ? '0 : prev - step;
            end
        endcase
    endfunction

    // Price sender: a new beat is offered only once the previous one is taken.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            price_tick <= '0;
            send_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                rsi_expected.push_back(predict_rsi_beat(price_tick));
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (price_backlog.size() != 0)
                begin
                    in_valid   <= 1'b1;
                    price_tick <= price_backlog.pop_front();
                    if (!calm_tail && $urandom_range(0, 99) < send_gap_pct)
                        send_gap <= $urandom_range(1, 14);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : result_check
        rsi_beat_t want;
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            sink_stall <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (rsi_expected.size() == 0)
                begin
                    $error("unexpected result beat: ready_res=%0d rsi_value=%0d",
                           ready_res, rsi_value);
                    mismatch_count++;
                end
                else
                begin
                    want = rsi_expected.pop_front();
                    if (ready_res !== want.ready)
                    begin
                        $error("ready_res: expected %0d, got %0d", want.ready, ready_res);
                        mismatch_count++;
                    end
                    if (rsi_value !== want.value)
                    begin
                        $error("rsi_value: expected %0d, got %0d", want.value, rsi_value);
                        mismatch_count++;
                    end
                end
            end
            if (sink_stall != 0)
            begin
                sink_stall <= sink_stall - 1;
                out_ready  <= 1'b0;
            end
            else if (!calm_tail && $urandom_range(0, 99) < sink_stall_pct)
            begin
                sink_stall <= $urandom_range(0, 13);
                out_ready  <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Waits until the unit holds no price and owes no result.
    task automatic drain();
        do
            @(negedge clk);
        while (price_backlog.size() != 0 || in_valid || rsi_expected.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_period(input logic [PERIOD_W-1:0] period);
        @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= period;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        period_q = period;
        clear_history();
        @(negedge clk);
    endtask

    initial
    begin : stimulus
        int                  counted;
        int                  count;
        int                  phase;
        logic [PERIOD_W-1:0] period;
        logic [31:0]         price;
        mismatch_count = 0;
        calm_tail      = 1'b0;
        send_gap_pct   = 20;
        sink_stall_pct = 5;
        period_q       = wrsi_pkg::PERIOD_RESET;
        clear_history();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset period: a flat run seeds both averages at zero, then a full-scale rise.
        repeat (15) price_backlog.push_back(32'd5000);
        price_backlog.push_back('1);
        drain();

        // Disabled block: every beat is not ready and nothing is remembered.
        write_period('0);
        price_backlog.push_back('0);
        price_backlog.push_back('1);
        price_backlog.push_back(32'd7);
        drain();

        // Period of one: full-scale fall, flat, full-scale rise and a fall again.
        write_period(PERIOD_W'(1));
        price_backlog.push_back('1);
        price_backlog.push_back('0);
        price_backlog.push_back('0);
        price_backlog.push_back('1);
        price_backlog.push_back(32'd12345);
        drain();

        counted = 0;
        phase   = 0;
        while (counted < RANDOM_PRICES)
        begin
            case (phase)
                0: period = PERIOD_W'(1);
                1: period = '1;
                2: period = '0;
                3: period = PERIOD_W'(2);
                4: period = PERIOD_W'(254);
                default: period = PERIOD_W'($urandom_range(2, 24));
            endcase
            if (period >= 254)
                count = 280;
            else if (period == 0)
                count = 12;
            else
                count = $urandom_range(15, 60);
            case ($urandom_range(0, 2))
                0: send_gap_pct = 0;
                1: send_gap_pct = 10;
                default: send_gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0: sink_stall_pct = 0;
                1: sink_stall_pct = 3;
                default: sink_stall_pct = 10;
            endcase
            if (counted >= RANDOM_PRICES - 80)
                calm_tail = 1'b1;
            write_period(period);
            price = $urandom;
            repeat (count)
            begin
                price = next_price(price);
                price_backlog.push_back(price);
            end
            drain();
            if (period != 0)
                counted += count;
            phase++;
        end

        repeat (250) @(posedge clk);
        if (mismatch_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("testbench: errors");
        $finish;
    end

endmodule
